// File: design/tpfpc_pkg.sv
// Shared types, constants and helpers for the period and phase capture timer.
`default_nettype none

package tpfpc_pkg;

    // Counter width default and reported width of the wide counters
    localparam int COUNT_WIDTH_DEF = 32;
    localparam int REPORT_W        = 32;

    // Configuration reset values
    localparam logic [7:0]  TICKS_PER_MS_RST  = 8'd4;
    localparam logic [15:0] MS_PER_SECOND_RST = 16'd1000;

    // Configuration register indexes
    localparam int         CFG_IDX_W         = 1;
    localparam logic [0:0] CFG_TICKS_PER_MS  = 1'b0;
    localparam logic [0:0] CFG_MS_PER_SECOND = 1'b1;

    // Event commands
    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_VEDGE = 2'd1,
        CMD_IEDGE = 2'd2,
        CMD_LOAD  = 2'd3
    } t_cmd;

    // Timeout selectors for a load
    localparam logic [1:0] SEL_LINK    = 2'd0;
    localparam logic [1:0] SEL_GENERAL = 2'd1;
    localparam logic [1:0] SEL_SAMPLE  = 2'd2;

    // One input item
    typedef struct packed {
        t_cmd        command;
        logic [1:0]  timeout_select;
        logic [15:0] timeout_value;
        logic        sampling_active;
    } t_item;

    // One result item
    typedef struct packed {
        logic        half_second_pulse;
        logic        second_pulse;
        logic [31:0] frequency_sum;
        logic [15:0] edge_count;
        logic [31:0] phase_ticks;
        logic [15:0] link_timeout_left;
        logic [15:0] general_timeout_left;
        logic [15:0] sample_timeout_left;
    } t_result;

    // Saturating decrement: zero stays zero
    function automatic logic [15:0] count_down(input logic [15:0] v);
        return (v != 16'd0) ? (v - 16'd1) : 16'd0;
    endfunction

endpackage

`default_nettype wire

// File: design/tpfpc_in_stage.sv
// Input register stage: holds one accepted item until the core consumes it.
`default_nettype none

module tpfpc_in_stage (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_tvalid,
    output logic                 o_tready,
    input  wire tpfpc_pkg::t_item i_item,
    input  wire logic            i_take,
    output logic                 o_valid,
    output tpfpc_pkg::t_item     o_item
);

    logic             r_valid;
    tpfpc_pkg::t_item r_item;

    // Room when empty or when the held item leaves this cycle
    assign o_tready = !r_valid || i_take;
    assign o_valid  = r_valid;
    assign o_item   = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_tvalid && o_tready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_tvalid && o_tready) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

// File: design/tpfpc_core.sv
// Timer state, configuration registers and single-pass event update.
`default_nettype none

module tpfpc_core #(
    parameter int COUNT_WIDTH = tpfpc_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [tpfpc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [15:0]                     i_cfg_data,
    input  wire logic                            i_adv,
    input  wire tpfpc_pkg::t_item                i_item,
    output tpfpc_pkg::t_result                   o_result
);

    localparam int ExtW = (COUNT_WIDTH > tpfpc_pkg::REPORT_W) ? COUNT_WIDTH
                                                              : tpfpc_pkg::REPORT_W;

    // Configuration
    logic [7:0]  r_ticks_per_ms;
    logic [15:0] r_ms_per_second;

    // State
    logic [7:0]             r_ms_prescale,     n_ms_prescale;
    logic [15:0]            r_second_prescale, n_second_prescale;
    logic [COUNT_WIDTH-1:0] r_ticks_since_edge, n_ticks_since_edge;
    logic [COUNT_WIDTH-1:0] r_period_accum,    n_period_accum;
    logic [COUNT_WIDTH-1:0] r_freq_latched,    n_freq_latched;
    logic [COUNT_WIDTH-1:0] r_phase_counter,   n_phase_counter;
    logic [COUNT_WIDTH-1:0] r_phase_capture,   n_phase_capture;
    logic [15:0]            r_edges_seen,      n_edges_seen;
    logic [15:0]            r_link_timeout,    n_link_timeout;
    logic [15:0]            r_general_timeout, n_general_timeout;
    logic [15:0]            r_sample_timeout,  n_sample_timeout;
    logic                   w_half_pulse;
    logic                   w_sec_pulse;
    logic [ExtW-1:0]        w_freq_ext;
    logic [ExtW-1:0]        w_phase_ext;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks_per_ms  <= tpfpc_pkg::TICKS_PER_MS_RST;
            r_ms_per_second <= tpfpc_pkg::MS_PER_SECOND_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tpfpc_pkg::CFG_TICKS_PER_MS:  r_ticks_per_ms  <= i_cfg_data[7:0];
                tpfpc_pkg::CFG_MS_PER_SECOND: r_ms_per_second <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Next state for one event
    always_comb begin
        n_ms_prescale      = r_ms_prescale;
        n_second_prescale  = r_second_prescale;
        n_ticks_since_edge = r_ticks_since_edge;
        n_period_accum     = r_period_accum;
        n_freq_latched     = r_freq_latched;
        n_phase_counter    = r_phase_counter;
        n_phase_capture    = r_phase_capture;
        n_edges_seen       = r_edges_seen;
        n_link_timeout     = r_link_timeout;
        n_general_timeout  = r_general_timeout;
        n_sample_timeout   = r_sample_timeout;
        w_half_pulse       = 1'b0;
        w_sec_pulse        = 1'b0;
        unique case (i_item.command)
            tpfpc_pkg::CMD_TICK: begin
                n_phase_counter    = r_phase_counter + 1'b1;
                n_ticks_since_edge = r_ticks_since_edge + 1'b1;
                if (i_item.sampling_active) begin
                    n_sample_timeout = tpfpc_pkg::count_down(r_sample_timeout);
                end
                n_ms_prescale = r_ms_prescale - 8'd1;
                // Millisecond boundary
                if (n_ms_prescale == 8'd0) begin
                    n_ms_prescale     = r_ticks_per_ms;
                    n_link_timeout    = tpfpc_pkg::count_down(r_link_timeout);
                    n_second_prescale = r_second_prescale - 16'd1;
                    // Half point checked first, then full second
                    if (n_second_prescale == {1'b0, r_ms_per_second[15:1]}) begin
                        w_half_pulse = 1'b1;
                    end else if (n_second_prescale == 16'd0) begin
                        n_second_prescale = r_ms_per_second;
                        w_half_pulse      = 1'b1;
                        w_sec_pulse       = 1'b1;
                        n_freq_latched    = r_period_accum;
                        n_period_accum    = '0;
                        n_general_timeout = tpfpc_pkg::count_down(r_general_timeout);
                    end
                end
            end
            tpfpc_pkg::CMD_VEDGE: begin
                n_edges_seen       = r_edges_seen + 16'd1;
                n_period_accum     = r_period_accum + r_ticks_since_edge;
                n_ticks_since_edge = '0;
                n_phase_capture    = r_phase_counter;
            end
            tpfpc_pkg::CMD_IEDGE: begin
                n_phase_counter = '0;
            end
            tpfpc_pkg::CMD_LOAD: begin
                unique case (i_item.timeout_select)
                    tpfpc_pkg::SEL_LINK:    n_link_timeout    = i_item.timeout_value;
                    tpfpc_pkg::SEL_GENERAL: n_general_timeout = i_item.timeout_value;
                    tpfpc_pkg::SEL_SAMPLE:  n_sample_timeout  = i_item.timeout_value;
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // Result from the post-event state; wide counters report their low bits
    assign w_freq_ext  = ExtW'(n_freq_latched);
    assign w_phase_ext = ExtW'(n_phase_capture);

    always_comb begin
        o_result.half_second_pulse    = w_half_pulse;
        o_result.second_pulse         = w_sec_pulse;
        o_result.frequency_sum        = w_freq_ext[tpfpc_pkg::REPORT_W-1:0];
        o_result.edge_count           = n_edges_seen;
        o_result.phase_ticks          = w_phase_ext[tpfpc_pkg::REPORT_W-1:0];
        o_result.link_timeout_left    = n_link_timeout;
        o_result.general_timeout_left = n_general_timeout;
        o_result.sample_timeout_left  = n_sample_timeout;
    end

    // State registers, updated once per consumed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ms_prescale      <= tpfpc_pkg::TICKS_PER_MS_RST;
            r_second_prescale  <= tpfpc_pkg::MS_PER_SECOND_RST;
            r_ticks_since_edge <= '0;
            r_period_accum     <= '0;
            r_freq_latched     <= '0;
            r_phase_counter    <= '0;
            r_phase_capture    <= '0;
            r_edges_seen       <= '0;
            r_link_timeout     <= '0;
            r_general_timeout  <= '0;
            r_sample_timeout   <= '0;
        end else if (i_adv) begin
            r_ms_prescale      <= n_ms_prescale;
            r_second_prescale  <= n_second_prescale;
            r_ticks_since_edge <= n_ticks_since_edge;
            r_period_accum     <= n_period_accum;
            r_freq_latched     <= n_freq_latched;
            r_phase_counter    <= n_phase_counter;
            r_phase_capture    <= n_phase_capture;
            r_edges_seen       <= n_edges_seen;
            r_link_timeout     <= n_link_timeout;
            r_general_timeout  <= n_general_timeout;
            r_sample_timeout   <= n_sample_timeout;
        end
    end

endmodule

`default_nettype wire

// File: design/tpfpc_out_stage.sv
// Output result register: holds one result until the downstream side takes it.
`default_nettype none

module tpfpc_out_stage (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_load,
    input  wire tpfpc_pkg::t_result i_result,
    output logic                    o_can_load,
    output logic                    o_tvalid,
    input  wire logic               i_tready,
    output tpfpc_pkg::t_result      o_result
);

    logic               r_valid;
    tpfpc_pkg::t_result r_result;

    // Free when empty or when the held result is taken this cycle
    assign o_can_load = !r_valid || i_tready;
    assign o_tvalid   = r_valid;
    assign o_result   = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire

// File: design/tick_prescaler_freq_phase_capture.sv
// An accepted item is held in the input register, then its result is loaded into
// the result register and shown on o_m_tvalid. Throughput: one item per cycle while
// the result register has room; each item is one pass through the update logic.
// Reset (i_rst_n low, synchronous): prescalers reload 4 and 1000, all counters,
// timeouts and captures clear, both stages empty. Configuration is always ready.
`default_nettype none

module tick_prescaler_freq_phase_capture #(
    parameter int COUNT_WIDTH = tpfpc_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Input items
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    input  wire logic [23:0]                     i_s_tdata,  // timeout_value[15:0],
                                                             // sampling_active[16], zero[23:17]
    input  wire logic [3:0]                      i_s_tuser,  // command[1:0], timeout_select[3:2]
    // Result items
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    output logic [135:0]                         o_m_tdata,  // half_second_pulse[0],
                                                             // second_pulse[1],
                                                             // frequency_sum[33:2],
                                                             // edge_count[49:34],
                                                             // phase_ticks[81:50],
                                                             // link_timeout_left[97:82],
                                                             // general_timeout_left[113:98],
                                                             // sample_timeout_left[129:114],
                                                             // zero[135:130]
    // Configuration writes
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [tpfpc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [15:0]                     i_cfg_data
);

    tpfpc_pkg::t_item   w_in_item;
    tpfpc_pkg::t_item   w_item;
    tpfpc_pkg::t_result w_core_result;
    tpfpc_pkg::t_result w_out_result;
    logic               w_item_valid;
    logic               w_can_load;
    logic               w_adv;

    // Unpack the input item
    always_comb begin
        w_in_item.command         = tpfpc_pkg::t_cmd'(i_s_tuser[1:0]);
        w_in_item.timeout_select  = i_s_tuser[3:2];
        w_in_item.timeout_value   = i_s_tdata[15:0];
        w_in_item.sampling_active = i_s_tdata[16];
    end

    assign o_cfg_ready = 1'b1;

    // The held item is processed whenever the result register has room
    assign w_adv = w_item_valid && w_can_load;

    tpfpc_in_stage u_in_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (i_s_tvalid),
        .o_tready (o_s_tready),
        .i_item   (w_in_item),
        .i_take   (w_adv),
        .o_valid  (w_item_valid),
        .o_item   (w_item)
    );

    tpfpc_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_adv       (w_adv),
        .i_item      (w_item),
        .o_result    (w_core_result)
    );

    tpfpc_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_adv),
        .i_result   (w_core_result),
        .o_can_load (w_can_load),
        .o_tvalid   (o_m_tvalid),
        .i_tready   (i_m_tready),
        .o_result   (w_out_result)
    );

    // Pack the result item
    assign o_m_tdata = {6'd0,
                        w_out_result.sample_timeout_left,
                        w_out_result.general_timeout_left,
                        w_out_result.link_timeout_left,
                        w_out_result.phase_ticks,
                        w_out_result.edge_count,
                        w_out_result.frequency_sum,
                        w_out_result.second_pulse,
                        w_out_result.half_second_pulse};

`ifndef SYNTHESIS
    // Only a tick can produce second markers
    a_pulse_only_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && (w_item.command != tpfpc_pkg::CMD_TICK)
        |=> !w_out_result.half_second_pulse && !w_out_result.second_pulse)
        else $error("second marker on a non-tick item");

    // A full second is always also a half-second marker
    a_second_implies_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && w_out_result.second_pulse |-> w_out_result.half_second_pulse)
        else $error("second pulse without half-second pulse");

    // A processed item always lands in the result register
    a_adv_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> o_m_tvalid)
        else $error("processed item produced no result");
`endif

endmodule

`default_nettype wire

// File: test/tick_prescaler_freq_phase_capture_test.sv
// Self-checking bench for the period and phase capture timer: directed plan plus random phases.
`timescale 1ns / 100ps

module tick_prescaler_freq_phase_capture_test;

    import tpfpc_pkg::*;

    // Load selector with no timeout behind it
    localparam logic [1:0] SEL_UNUSED = 2'd3;
    localparam int LIMIT_CYCLES = 400000;
    localparam int LONG_HOLD    = 250;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind         kind;
        t_item             item;
        bit                typed;
        t_result           want;
        logic [CFG_IDX_W-1:0] idx;
        logic [15:0]       data;
    } t_row;

    // Random phases: prescaler settings, item count, share of ticks
    int ph_tpm[3]   = '{1, 3, 255};
    int ph_mps[3]   = '{2, 5, 65535};
    int ph_items[3] = '{900, 220, 60};
    int ph_ticks[3] = '{92, 75, 70};

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [23:0]          i_s_tdata;   // timeout_value[15:0], sampling_active[16], zero[23:17]
    logic [3:0]           i_s_tuser;   // command[1:0], timeout_select[3:2]
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    logic [135:0]         o_m_tdata;   // half[0], second[1], freq[33:2], edges[49:34],
                                       // phase[81:50], link[97:82], general[113:98],
                                       // sample[129:114], zero[135:130]
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [15:0]          i_cfg_data;

    // Timer model state
    logic [7:0]  cfg_tpm;
    logic [15:0] cfg_mps;
    logic [7:0]  ms_cnt;
    logic [15:0] sec_cnt;
    logic [31:0] ticks_since;
    logic [31:0] period_sum;
    logic [31:0] freq_hold;
    logic [31:0] phase_cnt;
    logic [31:0] phase_hold;
    logic [15:0] edge_cnt;
    logic [15:0] link_left;
    logic [15:0] gen_left;
    logic [15:0] samp_left;

    t_result timer_results_q[$];
    t_row    plan[$];
    int      mismatches   = 0;
    int      items_sent   = 0;
    int      results_seen = 0;
    int      cycles       = 0;

    tick_prescaler_freq_phase_capture u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Advance the timer model by one item, return the state it reports
    function automatic t_result advance_timer(input t_item it);
        t_result r;
        r = '0;
        case (it.command)
            CMD_TICK: begin
                phase_cnt   = phase_cnt + 32'd1;
                ticks_since = ticks_since + 32'd1;
                if (it.sampling_active && samp_left != 16'd0)
                    samp_left = samp_left - 16'd1;
                ms_cnt = ms_cnt - 8'd1;
                if (ms_cnt == 8'd0) begin
                    ms_cnt = cfg_tpm;
                    if (link_left != 16'd0)
                        link_left = link_left - 16'd1;
                    sec_cnt = sec_cnt - 16'd1;
                    // half test first: a half point of zero never reloads
                    if (sec_cnt == (cfg_mps >> 1)) begin
                        r.half_second_pulse = 1'b1;
                    end else if (sec_cnt == 16'd0) begin
                        sec_cnt = cfg_mps;
                        r.half_second_pulse = 1'b1;
                        r.second_pulse = 1'b1;
                        freq_hold  = period_sum;
                        period_sum = 32'd0;
                        if (gen_left != 16'd0)
                            gen_left = gen_left - 16'd1;
                    end
                end
            end
            CMD_VEDGE: begin
                edge_cnt    = edge_cnt + 16'd1;
                period_sum  = period_sum + ticks_since;
                ticks_since = 32'd0;
                phase_hold  = phase_cnt;
            end
            CMD_IEDGE: begin
                phase_cnt = 32'd0;
            end
            default: begin
                case (it.timeout_select)
                    SEL_LINK:    link_left = it.timeout_value;
                    SEL_GENERAL: gen_left  = it.timeout_value;
                    SEL_SAMPLE:  samp_left = it.timeout_value;
                    default: ;
                endcase
            end
        endcase
        r.frequency_sum        = freq_hold;
        r.edge_count           = edge_cnt;
        r.phase_ticks          = phase_hold;
        r.link_timeout_left    = link_left;
        r.general_timeout_left = gen_left;
        r.sample_timeout_left  = samp_left;
        return r;
    endfunction

    function automatic t_item mk_item(input t_cmd cmd, input logic [1:0] sel,
                                      input logic [15:0] val, input logic samp);
        t_item it;
        it.command         = cmd;
        it.timeout_select  = sel;
        it.timeout_value   = val;
        it.sampling_active = samp;
        return it;
    endfunction

    function automatic t_result mk_result(input logic half, input logic sec,
                                          input logic [31:0] freq, input logic [15:0] edges,
                                          input logic [31:0] phase, input logic [15:0] link,
                                          input logic [15:0] gen, input logic [15:0] samp);
        t_result r;
        r.half_second_pulse    = half;
        r.second_pulse         = sec;
        r.frequency_sum        = freq;
        r.edge_count           = edges;
        r.phase_ticks          = phase;
        r.link_timeout_left    = link;
        r.general_timeout_left = gen;
        r.sample_timeout_left  = samp;
        return r;
    endfunction

    function automatic void plan_item(input t_item it, input bit typed, input t_result want);
        t_row row;
        row.kind  = ROW_ITEM;
        row.item  = it;
        row.typed = typed;
        row.want  = want;
        row.idx   = CFG_TICKS_PER_MS;
        row.data  = 16'd0;
        plan.push_back(row);
    endfunction

    function automatic void plan_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        t_row row;
        row.kind  = ROW_CFG;
        row.item  = '0;
        row.typed = 1'b0;
        row.want  = '0;
        row.idx   = idx;
        row.data  = data;
        plan.push_back(row);
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one item, wait for acceptance, record what it should produce
    task automatic send_item(input t_item it, input bit typed, input t_result want);
        int gap;
        t_result pred;
        gap = pick_gap();
        if ((items_sent / 50) % 5 == 4)
            gap = 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {7'd0, it.sampling_active, it.timeout_value};
        i_s_tuser  <= {it.timeout_select, it.command};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        pred = advance_timer(it);
        timer_results_q.push_back(typed ? want : pred);
        items_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_TICKS_PER_MS)
            cfg_tpm = data[7:0];
        else
            cfg_mps = data;
        @(posedge i_clk);
    endtask

    // Stop offering and wait until every pending result is back
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (timer_results_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Stimulus: directed plan, then random phases
    initial begin : stimulus
        t_item it;
        t_cmd  cmd;
        int    r;
        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tuser   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        cfg_tpm     = TICKS_PER_MS_RST;
        cfg_mps     = MS_PER_SECOND_RST;
        ms_cnt      = TICKS_PER_MS_RST;
        sec_cnt     = MS_PER_SECOND_RST;
        ticks_since = '0;
        period_sum  = '0;
        freq_hold   = '0;
        phase_cnt   = '0;
        phase_hold  = '0;
        edge_cnt    = '0;
        link_left   = '0;
        gen_left    = '0;
        samp_left   = '0;

        // Loads from reset, unknown selector, timeouts held at zero, edges
        plan_item(mk_item(CMD_LOAD, SEL_LINK, 16'hFFFF, 1'b0), 1'b1,
                  mk_result(1'b0, 1'b0, 32'd0, 16'd0, 32'd0, 16'hFFFF, 16'd0, 16'd0));
        plan_item(mk_item(CMD_LOAD, SEL_GENERAL, 16'hFFFF, 1'b1), 1'b1,
                  mk_result(1'b0, 1'b0, 32'd0, 16'd0, 32'd0, 16'hFFFF, 16'hFFFF, 16'd0));
        plan_item(mk_item(CMD_LOAD, SEL_SAMPLE, 16'h0001, 1'b0), 1'b1,
                  mk_result(1'b0, 1'b0, 32'd0, 16'd0, 32'd0, 16'hFFFF, 16'hFFFF, 16'd1));
        plan_item(mk_item(CMD_LOAD, SEL_UNUSED, 16'hAAAA, 1'b1), 1'b1,
                  mk_result(1'b0, 1'b0, 32'd0, 16'd0, 32'd0, 16'hFFFF, 16'hFFFF, 16'd1));
        plan_item(mk_item(CMD_TICK, SEL_UNUSED, 16'h5555, 1'b1), 1'b1,
                  mk_result(1'b0, 1'b0, 32'd0, 16'd0, 32'd0, 16'hFFFF, 16'hFFFF, 16'd0));
        plan_item(mk_item(CMD_TICK, SEL_LINK, 16'h0000, 1'b1), 1'b1,
                  mk_result(1'b0, 1'b0, 32'd0, 16'd0, 32'd0, 16'hFFFF, 16'hFFFF, 16'd0));
        plan_item(mk_item(CMD_VEDGE, SEL_SAMPLE, 16'hFFFF, 1'b1), 1'b1,
                  mk_result(1'b0, 1'b0, 32'd0, 16'd1, 32'd2, 16'hFFFF, 16'hFFFF, 16'd0));
        plan_item(mk_item(CMD_IEDGE, SEL_GENERAL, 16'hFFFF, 1'b1), 1'b1,
                  mk_result(1'b0, 1'b0, 32'd0, 16'd1, 32'd2, 16'hFFFF, 16'hFFFF, 16'd0));
        plan_item(mk_item(CMD_TICK, SEL_LINK, 16'h0000, 1'b0), 1'b0, '0);
        plan_item(mk_item(CMD_TICK, SEL_LINK, 16'hFFFF, 1'b0), 1'b0, '0);
        plan_item(mk_item(CMD_VEDGE, SEL_LINK, 16'h0000, 1'b0), 1'b0, '0);
        plan_item(mk_item(CMD_LOAD, SEL_LINK, 16'h0000, 1'b0), 1'b0, '0);
        plan_item(mk_item(CMD_LOAD, SEL_SAMPLE, 16'hFFFF, 1'b1), 1'b0, '0);
        plan_item(mk_item(CMD_TICK, SEL_LINK, 16'h0000, 1'b1), 1'b0, '0);
        // Prescaler reload of zero (upper data bits ignored) and half point of zero
        plan_cfg(CFG_TICKS_PER_MS, 16'hFF00);
        plan_cfg(CFG_MS_PER_SECOND, 16'd1);
        plan_item(mk_item(CMD_TICK, SEL_LINK, 16'h0000, 1'b1), 1'b0, '0);
        plan_item(mk_item(CMD_TICK, SEL_LINK, 16'h0000, 1'b0), 1'b0, '0);
        plan_item(mk_item(CMD_TICK, SEL_LINK, 16'h0000, 1'b1), 1'b0, '0);
        plan_item(mk_item(CMD_TICK, SEL_LINK, 16'h0000, 1'b0), 1'b0, '0);
        plan_item(mk_item(CMD_VEDGE, SEL_LINK, 16'h0000, 1'b0), 1'b0, '0);
        plan_item(mk_item(CMD_IEDGE, SEL_LINK, 16'h0000, 1'b0), 1'b0, '0);
        plan_item(mk_item(CMD_LOAD, SEL_UNUSED, 16'h0000, 1'b0), 1'b0, '0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed plan
        foreach (plan[n]) begin
            if (plan[n].kind == ROW_CFG) begin
                drain_results();
                write_reg(plan[n].idx, plan[n].data);
            end else begin
                send_item(plan[n].item, plan[n].typed, plan[n].want);
            end
        end

        // Random phases, each under its own prescaler setting
        for (int p = 0; p < 3; p++) begin
            drain_results();
            write_reg(CFG_TICKS_PER_MS, 16'(ph_tpm[p]));
            write_reg(CFG_MS_PER_SECOND, 16'(ph_mps[p]));
            for (int k = 0; k < ph_items[p]; k++) begin
                r = $urandom_range(0, 99);
                if (r < ph_ticks[p]) begin
                    cmd = CMD_TICK;
                end else begin
                    case ($urandom_range(0, 2))
                        0:       cmd = CMD_VEDGE;
                        1:       cmd = CMD_IEDGE;
                        default: cmd = CMD_LOAD;
                    endcase
                end
                it.command         = cmd;
                it.timeout_select  = 2'($urandom_range(0, 3));
                // small loads let the timeouts reach zero
                it.timeout_value   = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 4))
                                                                 : 16'($urandom);
                it.sampling_active = 1'($urandom);
                send_item(it, 1'b0, '0);
            end
        end

        drain_results();
        if (mismatches == 0)
            $display("[tick_prescaler_freq_phase_capture] OK");
        else
            $display("[tick_prescaler_freq_phase_capture] ERROR");
        $finish;
    end

    // Result sink: random back-pressure, one long hold, field checks
    initial begin : result_sink
        t_result got;
        t_result want;
        int      stall_left;
        bit      long_done;
        i_m_tready <= 1'b0;
        stall_left = 0;
        long_done  = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (o_m_tvalid && i_m_tready) begin
                got.half_second_pulse    = o_m_tdata[0];
                got.second_pulse         = o_m_tdata[1];
                got.frequency_sum        = o_m_tdata[33:2];
                got.edge_count           = o_m_tdata[49:34];
                got.phase_ticks          = o_m_tdata[81:50];
                got.link_timeout_left    = o_m_tdata[97:82];
                got.general_timeout_left = o_m_tdata[113:98];
                got.sample_timeout_left  = o_m_tdata[129:114];
                results_seen++;
                if (timer_results_q.size() == 0) begin
                    $display("%0t: result with nothing pending, got %0h", $time, o_m_tdata);
                    mismatches++;
                end else begin
                    want = timer_results_q.pop_front();
                    check_field("half_second_pulse", 32'(want.half_second_pulse),
                                32'(got.half_second_pulse));
                    check_field("second_pulse", 32'(want.second_pulse),
                                32'(got.second_pulse));
                    check_field("frequency_sum", want.frequency_sum, got.frequency_sum);
                    check_field("edge_count", 32'(want.edge_count), 32'(got.edge_count));
                    check_field("phase_ticks", want.phase_ticks, got.phase_ticks);
                    check_field("link_timeout_left", 32'(want.link_timeout_left),
                                32'(got.link_timeout_left));
                    check_field("general_timeout_left", 32'(want.general_timeout_left),
                                32'(got.general_timeout_left));
                    check_field("sample_timeout_left", 32'(want.sample_timeout_left),
                                32'(got.sample_timeout_left));
                end
            end
            // Pick ready for the next edge
            if (stall_left > 0) begin
                i_m_tready <= 1'b0;
                stall_left--;
            end else if (!long_done && results_seen >= 300) begin
                // long hold so the block fills and stalls its input
                long_done  = 1'b1;
                stall_left = LONG_HOLD - 1;
                i_m_tready <= 1'b0;
            end else if ((cycles / 400) % 4 == 3) begin
                i_m_tready <= 1'b1;
            end else begin
                stall_left = pick_gap();
                if (stall_left > 0) begin
                    stall_left--;
                    i_m_tready <= 1'b0;
                end else begin
                    i_m_tready <= 1'b1;
                end
            end
            @(posedge i_clk);
        end
    end

    // Run limit
    initial begin : watchdog
        while (cycles <= LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("[tick_prescaler_freq_phase_capture] ERROR");
        $finish;
    end

endmodule

// File: files.f
design/tpfpc_pkg.sv
design/tpfpc_in_stage.sv
design/tpfpc_core.sv
design/tpfpc_out_stage.sv
design/tick_prescaler_freq_phase_capture.sv
test/tick_prescaler_freq_phase_capture_test.sv
